@@ hdl/iks_pkg.sv @@
// shared types and constants for the idea key schedule unit
`timescale 1ns / 1ps
package iks_pkg;

  localparam int unsigned NumSubkeys = 52;
  localparam int unsigned IdxW       = 6;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSubkeys - 1);

  // kind of transform applied to an encryption subkey on the decryption path
  typedef enum logic [1:0] {
    XF_NONE = 2'd0,
    XF_MUL  = 2'd1,
    XF_ADD  = 2'd2
  } xform_e;

  // controller to datapath
  typedef struct packed {
    logic            load;     // capture key
    logic [IdxW-1:0] src;      // encryption subkey index to read
    logic            inv_go;   // start multiplicative inverse
    logic            neg;      // take additive inverse
    logic            capture;  // latch plain or negated value into result
  } iks_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic inv_done;
  } iks_sts_t;

  // source encryption index for decryption position k, with its transform
  function automatic logic [IdxW+1:0] dec_map(input logic [IdxW-1:0] k);
    logic [IdxW-1:0] src;
    xform_e          xf;
    int unsigned     r;
    int unsigned     p;
    begin
      src = '0;
      xf  = XF_NONE;
      r   = 0;
      p   = 0;
      if (k < 4) begin
        src = IdxW'(48 + int'(k));
        xf  = (k == 0 || k == 3) ? XF_MUL : XF_ADD;
      end else begin
        // round and slot within the round, by compare against each round start
        for (int unsigned j = 0; j < 8; j++) begin
          if (32'(k) >= 4 + 6 * j) begin
            r = j;
            p = 32'(k) - 4 - 6 * j;
          end
        end
        case (p)
          0: begin src = IdxW'(46 - 6 * r); xf = XF_NONE; end
          1: begin src = IdxW'(47 - 6 * r); xf = XF_NONE; end
          2: begin src = IdxW'(42 - 6 * r); xf = XF_MUL;  end
          3: begin src = (r == 7) ? IdxW'(1) : IdxW'(44 - 6 * r); xf = XF_ADD; end
          4: begin src = (r == 7) ? IdxW'(2) : IdxW'(43 - 6 * r); xf = XF_ADD; end
          default: begin src = IdxW'(45 - 6 * r); xf = XF_MUL; end
        endcase
      end
      dec_map = {xf, src};
    end
  endfunction

endpackage

@@ hdl/iks_if.sv @@
// valid/ready channel interfaces for key input and subkey output
`timescale 1ns / 1ps
interface iks_key_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] key_high;
  logic [63:0] key_low;
  modport source (output valid, mode, key_high, key_low, input ready);
  modport sink   (input valid, mode, key_high, key_low, output ready);
endinterface

interface iks_sub_if;
  logic        valid;
  logic        ready;
  logic [15:0] subkey;
  logic [5:0]  subkey_index;
  logic        last;
  modport source (output valid, subkey, subkey_index, last, input ready);
  modport sink   (input valid, subkey, subkey_index, last, output ready);
endinterface

@@ hdl/iks_datapath.sv @@
// key register, encryption subkey extraction, inverse unit and result value
`timescale 1ns / 1ps
module iks_datapath import iks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  input  iks_cmd_t    cmd_i,
  output iks_sts_t    sts_o,
  output logic [15:0] value_o
);

  logic [127:0] key_q;
  logic [15:0]  ek;
  logic [2:0]   blk;
  logic [6:0]   rot;
  logic [127:0] rkey;
  logic [16:0]  base_q, acc_q;
  logic [15:0]  exp_q;
  logic         busy_q;
  logic         phase_q;   // 0 multiply acc, 1 square base
  logic [33:0]  prod_q;
  logic         pvalid_q;
  logic [15:0]  value_q;

  // subkey k is word k%8 of the key rotated left by 25*(k/8)
  assign blk = cmd_i.src[5:3];
  always_comb begin
    rot  = 7'(25 * int'(blk));
    rkey = (key_q << rot) | (key_q >> (7'd0 - rot));
    ek   = rkey[127 - 16 * int'(cmd_i.src[2:0]) -: 16];
  end

  // 17-bit mod 65537 product reduction: 2^16 = -1
  function automatic logic [16:0] mod_red(input logic [33:0] p);
    logic [17:0] lo, hi;
    logic [18:0] t;
    begin
      // p < 2^33; write p = a*2^32 + b*2^16 + c -> c - b + a
      lo = {2'b0, p[15:0]} + {17'b0, p[32]};
      hi = {2'b0, p[31:16]};
      t  = {1'b0, lo} + 19'd65537 - {1'b0, hi};
      if (t >= 19'd65537) t = t - 19'd65537;
      if (t >= 19'd65537) t = t - 19'd65537;
      mod_red = t[16:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pvalid_q <= 1'b0;
      phase_q  <= 1'b0;
    end else begin
      pvalid_q <= 1'b0;
      if (cmd_i.inv_go) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        if (!pvalid_q) begin
          if (exp_q == '0) begin
            busy_q <= 1'b0;
          end else begin
            pvalid_q <= 1'b1;
            if (phase_q || !exp_q[0]) phase_q <= 1'b1;
          end
        end else begin
          phase_q <= !phase_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) key_q <= {key_high_i, key_low_i};
    if (cmd_i.inv_go) begin
      base_q <= (ek == '0) ? 17'h10000 : {1'b0, ek};
      acc_q  <= 17'd1;
      exp_q  <= 16'hFFFF;
    end else if (busy_q) begin
      if (!pvalid_q) begin
        if (exp_q != '0) begin
          if (!phase_q && exp_q[0]) prod_q <= {17'b0, acc_q} * {17'b0, base_q};
          else prod_q <= {17'b0, base_q} * {17'b0, base_q};
        end
      end else if (!phase_q) begin
        acc_q <= mod_red(prod_q);
      end else begin
        base_q <= mod_red(prod_q);
        exp_q  <= exp_q >> 1;
      end
    end
    if (cmd_i.capture) value_q <= cmd_i.neg ? 16'd0 - ek : ek;
    else if (busy_q && !pvalid_q && exp_q == '0) value_q <= acc_q[15:0];
  end

  assign sts_o.inv_done = busy_q && !pvalid_q && exp_q == '0;
  assign value_o        = value_q;

endmodule

@@ hdl/iks_ctrl.sv @@
// sequencer that walks the 52 subkey positions and drives the output
`timescale 1ns / 1ps
module iks_ctrl import iks_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_mode_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [IdxW-1:0] out_index_o,
  output logic            out_last_o,
  output iks_cmd_t        cmd_o,
  input  iks_sts_t        sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_INV, S_OUT
  } state_e;

  state_e          state_q;
  logic            mode_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW+1:0] map;
  xform_e          xf;

  assign map = dec_map(idx_q);
  assign xf  = mode_q ? xform_e'(map[IdxW+1:IdxW]) : XF_NONE;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.src     = mode_q ? map[IdxW-1:0] : idx_q;
    cmd_o.inv_go  = (state_q == S_SEL) && (xf == XF_MUL);
    cmd_o.capture = (state_q == S_SEL) && (xf != XF_MUL);
    cmd_o.neg     = (xf == XF_ADD);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          mode_q  <= in_mode_i;
          idx_q   <= '0;
          state_q <= S_SEL;
        end
        S_SEL: state_q <= (xf == XF_MUL) ? S_INV : S_OUT;
        S_INV: if (sts_i.inv_done) state_q <= S_OUT;
        S_OUT: if (out_ready_i) begin
          if (idx_q == LastIdx) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SEL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/idea_key_schedule_unit.sv @@
// top level of the idea key schedule unit
`timescale 1ns / 1ps
// Takes one 128-bit key and a mode bit and emits the 52 IDEA subkeys in order,
// marking the last. Each encryption subkey passes through a select state and an
// output state; each decryption multiplicative key runs a square-and-multiply
// inverse modulo 65537 in one shared 17x17 multiplier between select and output.
// A new key is taken only after the last subkey.
module idea_key_schedule_unit import iks_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  iks_key_if.sink   key_in,
  iks_sub_if.source sub_out
);

  iks_cmd_t    cmd;
  iks_sts_t    sts;
  logic [15:0] value;

  iks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_in.valid),
    .in_mode_i   (key_in.mode),
    .in_ready_o  (key_in.ready),
    .out_valid_o (sub_out.valid),
    .out_ready_i (sub_out.ready),
    .out_index_o (sub_out.subkey_index),
    .out_last_o  (sub_out.last),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  iks_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_high_i (key_in.key_high),
    .key_low_i  (key_in.key_low),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_o    (value)
  );

  assign sub_out.subkey = value;

endmodule

@@ hdl/iks_checker.sv @@
// port-level checks for the idea key schedule unit
`timescale 1ns / 1ps
module iks_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_index,
  input logic       out_last
);

  // no new key while a run is being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("key taken during run");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_index == 6'd51))) else $error("last mismatch");

  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> ##1 (!out_valid || out_index == 6'd0))
    else $error("run does not start at zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index)))
    else $error("word dropped");

endmodule

bind idea_key_schedule_unit iks_checker u_iks_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (key_in.valid),
  .in_ready  (key_in.ready),
  .out_valid (sub_out.valid),
  .out_ready (sub_out.ready),
  .out_index (sub_out.subkey_index),
  .out_last  (sub_out.last)
);
